[hdl/btpm_pkg.sv]
// ----------------------------------------------------------------------------
// btpm_pkg
// Shared widths, codes and item types of the barycentric triangle pixel mapper.
// ----------------------------------------------------------------------------
package btpm_pkg;

  localparam int CoordBits  = 13;
  localparam int PixBits    = 12;
  localparam int ColorBits  = 24;
  localparam int CfgBits    = 13;
  localparam int SlotBits   = 3;
  localparam int NumVerts   = 6;

  localparam int DiffBits   = CoordBits + 1;
  localparam int ProdBits   = 2 * DiffBits;
  localparam int WBits      = ProdBits + 2;
  localparam int DetBits    = WBits + 2;
  localparam int MapBits    = WBits + CoordBits;
  localparam int SumBits    = MapBits + 2;
  localparam int NumBits    = SumBits + 2;
  localparam int DivBits    = DetBits + 1;
  localparam int QBits      = PixBits;
  localparam int RemBits    = DivBits + QBits;

  localparam int QueueDepth = 16;
  localparam int QueueAw    = 4;
  localparam int CreditBits = QueueAw + 1;
  localparam int OutDepth   = 2;

  localparam logic [CfgBits-1:0] WidthReset  = CfgBits'(640);
  localparam logic [CfgBits-1:0] HeightReset = CfgBits'(480);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MAP  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [NumBits-1:0] num_x;
    logic signed [NumBits-1:0] num_y;
    logic [DivBits-1:0]        div;
    logic                      degenerate;
    logic [ColorBits-1:0]      color;
  } job_t;

  typedef struct packed {
    logic [QBits-1:0]     target_x;
    logic [QBits-1:0]     target_y;
    logic [ColorBits-1:0] color;
    logic                 write_flag;
    logic                 degenerate;
  } result_t;

endpackage

[hdl/btpm_front.sv]
// ----------------------------------------------------------------------------
// btpm_front
// Vertex store and weight pipeline: turns a pixel into rounding numerators.
// ----------------------------------------------------------------------------
module btpm_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  logic                                   command,
  input  logic [btpm_pkg::SlotBits-1:0]          vertex_slot,
  input  logic signed [btpm_pkg::CoordBits-1:0]  vertex_x,
  input  logic signed [btpm_pkg::CoordBits-1:0]  vertex_y,
  input  logic [btpm_pkg::PixBits-1:0]           pixel_x,
  input  logic [btpm_pkg::PixBits-1:0]           pixel_y,
  input  logic [btpm_pkg::ColorBits-1:0]         pixel_color,
  output logic                                   job_valid,
  output btpm_pkg::job_t                         job
);

  localparam int Cb = btpm_pkg::CoordBits;
  localparam int Db = btpm_pkg::DiffBits;
  localparam int Pb = btpm_pkg::ProdBits;
  localparam int Wb = btpm_pkg::WBits;
  localparam int Mb = btpm_pkg::MapBits;
  localparam int Sb = btpm_pkg::SumBits;
  localparam int Nb = btpm_pkg::NumBits;
  localparam int Eb = btpm_pkg::DetBits;
  localparam int Cl = btpm_pkg::ColorBits;

  logic signed [Cb-1:0] vx [btpm_pkg::NumVerts];
  logic signed [Cb-1:0] vy [btpm_pkg::NumVerts];

  logic map_in;
  logic signed [Db-1:0] pxs, pys;

  // stage 1: offsets to the pixel
  logic s1_valid;
  logic signed [Db-1:0] dax, day, dbx, dby, dcx, dcy;
  logic signed [Cb-1:0] s1_tx [3];
  logic signed [Cb-1:0] s1_ty [3];
  logic [Cl-1:0] s1_color;

  // stage 2: cross products
  logic s2_valid;
  logic signed [Pb-1:0] p_cb, p_bc, p_ac, p_ca, p_ba, p_ab;
  logic signed [Cb-1:0] s2_tx [3];
  logic signed [Cb-1:0] s2_ty [3];
  logic [Cl-1:0] s2_color;

  // stage 3: weights
  logic s3_valid;
  logic signed [Wb-1:0] w [3];
  logic signed [Cb-1:0] s3_tx [3];
  logic signed [Cb-1:0] s3_ty [3];
  logic [Cl-1:0] s3_color;

  // stage 4: weighted destination coordinates
  logic s4_valid;
  logic signed [Mb-1:0] mx [3];
  logic signed [Mb-1:0] my [3];
  logic signed [Eb-1:0] det;
  logic [Cl-1:0] s4_color;

  // stage 5: sums with sign folded into the numerator
  logic s5_valid;
  logic signed [Sb-1:0] nx, ny;
  logic [Eb-1:0] dabs;
  logic [Cl-1:0] s5_color;

  logic signed [Sb-1:0] sum_x, sum_y;

  assign map_in = accept && (command == btpm_pkg::CMD_MAP);
  assign pxs    = $signed({2'b00, pixel_x});
  assign pys    = $signed({2'b00, pixel_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < btpm_pkg::NumVerts; i++) begin
        vx[i] <= '0;
        vy[i] <= '0;
      end
    end else if (accept && (command == btpm_pkg::CMD_LOAD) &&
                 (vertex_slot < btpm_pkg::SlotBits'(btpm_pkg::NumVerts))) begin
      vx[vertex_slot] <= vertex_x;
      vy[vertex_slot] <= vertex_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      s1_valid <= map_in;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      job_valid <= s5_valid;
    end
  end

  assign sum_x = Sb'(mx[0]) + Sb'(mx[1]) + Sb'(mx[2]);
  assign sum_y = Sb'(my[0]) + Sb'(my[1]) + Sb'(my[2]);

  always_ff @(posedge clk) begin
    dax <= Db'(vx[0]) - pxs;
    day <= Db'(vy[0]) - pys;
    dbx <= Db'(vx[1]) - pxs;
    dby <= Db'(vy[1]) - pys;
    dcx <= Db'(vx[2]) - pxs;
    dcy <= Db'(vy[2]) - pys;
    for (int i = 0; i < 3; i++) begin
      s1_tx[i] <= vx[i+3];
      s1_ty[i] <= vy[i+3];
    end
    s1_color <= pixel_color;

    p_cb <= dcx * dby;
    p_bc <= dbx * dcy;
    p_ac <= dax * dcy;
    p_ca <= dcx * day;
    p_ba <= dbx * day;
    p_ab <= dax * dby;
    s2_tx <= s1_tx;
    s2_ty <= s1_ty;
    s2_color <= s1_color;

    w[0] <= Wb'(p_cb) - Wb'(p_bc);
    w[1] <= Wb'(p_ac) - Wb'(p_ca);
    w[2] <= Wb'(p_ba) - Wb'(p_ab);
    s3_tx <= s2_tx;
    s3_ty <= s2_ty;
    s3_color <= s2_color;

    for (int i = 0; i < 3; i++) begin
      mx[i] <= w[i] * Mb'(s3_tx[i]);
      my[i] <= w[i] * Mb'(s3_ty[i]);
    end
    det <= Eb'(w[0]) + Eb'(w[1]) + Eb'(w[2]);
    s4_color <= s3_color;

    if (det < 0) begin
      nx   <= -sum_x;
      ny   <= -sum_y;
      dabs <= $unsigned(-det);
    end else begin
      nx   <= sum_x;
      ny   <= sum_y;
      dabs <= $unsigned(det);
    end
    s5_color <= s4_color;

    job.num_x      <= (Nb'(nx) <<< 1) + $signed(Nb'(dabs));
    job.num_y      <= (Nb'(ny) <<< 1) + $signed(Nb'(dabs));
    job.div        <= {dabs, 1'b0};
    job.degenerate <= (dabs == '0);
    job.color      <= s5_color;
  end

endmodule

[hdl/btpm_queue.sv]
// ----------------------------------------------------------------------------
// btpm_queue
// Short first-in first-out buffer of jobs between front and back.
// ----------------------------------------------------------------------------
module btpm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  btpm_pkg::job_t wr_data,
  input  logic           rd,
  output logic           empty,
  output btpm_pkg::job_t rd_data
);

  localparam int Aw = btpm_pkg::QueueAw;

  btpm_pkg::job_t mem [btpm_pkg::QueueDepth];
  logic [Aw-1:0] wr_ptr, rd_ptr;
  logic [Aw:0]   count;

  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (Aw+1)'(wr) - (Aw+1)'(rd && !empty);
    end
  end

endmodule

[hdl/btpm_back.sv]
// ----------------------------------------------------------------------------
// btpm_back
// Range check, pipelined restoring division, bounds test and result buffer.
// ----------------------------------------------------------------------------
module btpm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_ready_n,
  input  btpm_pkg::job_t                job,
  output logic                          job_take,
  input  logic [btpm_pkg::CfgBits-1:0]  image_width,
  input  logic [btpm_pkg::CfgBits-1:0]  image_height,
  input  logic                          pop,
  output logic                          empty,
  output btpm_pkg::result_t             result
);

  localparam int Qb = btpm_pkg::QBits;
  localparam int Rb = btpm_pkg::RemBits;
  localparam int Nb = btpm_pkg::NumBits;
  localparam int Vb = btpm_pkg::DivBits;
  localparam int Cl = btpm_pkg::ColorBits;

  logic                 st_valid [Qb+1];
  logic [Rb-1:0]        rem_x    [Qb+1];
  logic [Rb-1:0]        rem_y    [Qb+1];
  logic [Qb-1:0]        q_x      [Qb+1];
  logic [Qb-1:0]        q_y      [Qb+1];
  logic                 ok_x     [Qb+1];
  logic                 ok_y     [Qb+1];
  logic [Vb-1:0]        dv       [Qb+1];
  logic                 deg      [Qb+1];
  logic [Cl-1:0]        col      [Qb+1];

  logic [1:0] ocnt;
  btpm_pkg::result_t obuf [btpm_pkg::OutDepth];
  btpm_pkg::result_t res;
  logic en, push, pop_ok;

  logic signed [Nb-1:0] lim;
  logic signed [Nb-1:0] dv_s;
  logic cls_ok_x, cls_ok_y;

  assign en       = (ocnt < 2'(btpm_pkg::OutDepth));
  assign job_take = en && !job_ready_n;

  assign lim  = $signed(Nb'({job.div, {Qb{1'b0}}}));
  assign dv_s = $signed(Nb'(job.div));

  // negative numerators above minus one divisor still round to zero
  always_comb begin
    if (job.num_x < 0) cls_ok_x = (job.num_x + dv_s) > 0;
    else               cls_ok_x = job.num_x < lim;
    if (job.num_y < 0) cls_ok_y = (job.num_y + dv_s) > 0;
    else               cls_ok_y = job.num_y < lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (en) begin
      st_valid[0] <= job_take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x[0] <= job.num_x[Nb-1] ? '0 : Rb'($unsigned(job.num_x));
      rem_y[0] <= job.num_y[Nb-1] ? '0 : Rb'($unsigned(job.num_y));
      q_x[0]   <= '0;
      q_y[0]   <= '0;
      ok_x[0]  <= cls_ok_x && !job.degenerate;
      ok_y[0]  <= cls_ok_y && !job.degenerate;
      dv[0]    <= job.div;
      deg[0]   <= job.degenerate;
      col[0]   <= job.color;
    end
  end

  for (genvar i = 1; i <= Qb; i++) begin : g_div
    logic [Rb-1:0] dsh;
    logic [Rb:0]   tx, ty;
    assign dsh = Rb'(dv[i-1]) << (Qb - i);
    assign tx  = {1'b0, rem_x[i-1]} - {1'b0, dsh};
    assign ty  = {1'b0, rem_y[i-1]} - {1'b0, dsh};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[i] <= 1'b0;
      end else if (en) begin
        st_valid[i] <= st_valid[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_x[i] <= tx[Rb] ? rem_x[i-1] : tx[Rb-1:0];
        rem_y[i] <= ty[Rb] ? rem_y[i-1] : ty[Rb-1:0];
        q_x[i]   <= {q_x[i-1][Qb-2:0], !tx[Rb]};
        q_y[i]   <= {q_y[i-1][Qb-2:0], !ty[Rb]};
        ok_x[i]  <= ok_x[i-1];
        ok_y[i]  <= ok_y[i-1];
        dv[i]    <= dv[i-1];
        deg[i]   <= deg[i-1];
        col[i]   <= col[i-1];
      end
    end
  end

  always_comb begin
    res.write_flag = ok_x[Qb] && ok_y[Qb] &&
                     ({1'b0, q_x[Qb]} < image_width) &&
                     ({1'b0, q_y[Qb]} < image_height);
    res.target_x   = res.write_flag ? q_x[Qb] : '0;
    res.target_y   = res.write_flag ? q_y[Qb] : '0;
    res.color      = col[Qb];
    res.degenerate = deg[Qb];
  end

  assign push   = en && st_valid[Qb];
  assign pop_ok = pop && (ocnt != '0);
  assign empty  = (ocnt == '0);
  assign result = obuf[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
    end else begin
      ocnt <= ocnt + 2'(push) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push && (ocnt == 2'd0 || (ocnt == 2'd1 && pop_ok))) begin
      obuf[0] <= res;
    end else if (pop_ok) begin
      obuf[0] <= obuf[1];
    end
    if (push && ocnt == 2'd1 && !pop_ok) begin
      obuf[1] <= res;
    end
  end

endmodule

[hdl/barycentric_triangle_pixel_mapper.sv]
// ----------------------------------------------------------------------------
// barycentric_triangle_pixel_mapper
// Maps source pixels into a destination triangle through barycentric weights.
// ----------------------------------------------------------------------------
// input queue: push an item while full is low; command selects a vertex load
// (vertex_slot, vertex_x, vertex_y) or a pixel map (pixel_x, pixel_y,
// pixel_color). loads give no result and take effect for the next item.
// result queue: while empty is low the oldest result is on target_x,
// target_y, color_out, write_flag and degenerate; pop takes it.
// image_width and image_height are written through cfg_write, cfg_index and
// cfg_data; the user must do it only with no pixel in flight (not enforced).
// a pixel reaches the result ports through the front stages, the job queue,
// the range check, twelve stages of the restoring divider (one quotient bit
// per stage) and the result buffer.
// one item is taken per cycle as long as results are popped.
// when pop stays low the divider pipeline freezes once the two-entry result
// buffer fills; the front keeps running into the 16-entry job queue and full
// rises when queued and in-flight pixels reach its depth.
// reset clears all vertices to zero, width to 640, height to 480, and
// empties both queues.
// ----------------------------------------------------------------------------
module barycentric_triangle_pixel_mapper (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   command,
  input  logic [btpm_pkg::SlotBits-1:0]          vertex_slot,
  input  logic signed [btpm_pkg::CoordBits-1:0]  vertex_x,
  input  logic signed [btpm_pkg::CoordBits-1:0]  vertex_y,
  input  logic [btpm_pkg::PixBits-1:0]           pixel_x,
  input  logic [btpm_pkg::PixBits-1:0]           pixel_y,
  input  logic [btpm_pkg::ColorBits-1:0]         pixel_color,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [btpm_pkg::QBits-1:0]             target_x,
  output logic [btpm_pkg::QBits-1:0]             target_y,
  output logic [btpm_pkg::ColorBits-1:0]         color_out,
  output logic                                   write_flag,
  output logic                                   degenerate,
  input  logic                                   cfg_write,
  input  logic                                   cfg_index,
  input  logic [btpm_pkg::CfgBits-1:0]           cfg_data
);

  logic accept, map_accept;
  logic job_valid, q_empty, q_take;
  btpm_pkg::job_t job, q_job;
  btpm_pkg::result_t result;
  logic [btpm_pkg::CfgBits-1:0] image_width, image_height;
  logic [btpm_pkg::CreditBits-1:0] credit;

  assign accept     = push && !full;
  assign map_accept = accept && (command == btpm_pkg::CMD_MAP);
  assign full       = (credit == btpm_pkg::CreditBits'(btpm_pkg::QueueDepth));

  // pixels in the front pipeline or the job queue
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + btpm_pkg::CreditBits'(map_accept)
                       - btpm_pkg::CreditBits'(q_take);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= btpm_pkg::WidthReset;
      image_height <= btpm_pkg::HeightReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        btpm_pkg::REG_WIDTH:  image_width  <= cfg_data;
        btpm_pkg::REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  btpm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (command),
    .vertex_slot (vertex_slot),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .job_valid   (job_valid),
    .job         (job)
  );

  btpm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_valid),
    .wr_data (job),
    .rd      (q_take),
    .empty   (q_empty),
    .rd_data (q_job)
  );

  btpm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_ready_n  (q_empty),
    .job          (q_job),
    .job_take     (q_take),
    .image_width  (image_width),
    .image_height (image_height),
    .pop          (pop),
    .empty        (empty),
    .result       (result)
  );

  assign target_x   = result.target_x;
  assign target_y   = result.target_y;
  assign color_out  = result.color;
  assign write_flag = result.write_flag;
  assign degenerate = result.degenerate;

endmodule

[hdl/btpm_checker.sv]
// ----------------------------------------------------------------------------
// btpm_checker
// Port-level checks of the pixel mapper, bound to the top level.
// ----------------------------------------------------------------------------
module btpm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         empty,
  input logic                         pop,
  input logic [btpm_pkg::QBits-1:0]   target_x,
  input logic [btpm_pkg::QBits-1:0]   target_y,
  input logic                         write_flag,
  input logic                         degenerate
);

  a_deg_no_write: assert property (@(posedge clk) disable iff (rst)
    !empty && degenerate |-> !write_flag)
    else $error("degenerate result carries a write");

  a_zero_target: assert property (@(posedge clk) disable iff (rst)
    !empty && !write_flag |-> (target_x == '0) && (target_y == '0))
    else $error("suppressed write has nonzero target");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("waiting result vanished");

endmodule

bind barycentric_triangle_pixel_mapper btpm_checker u_btpm_checker (.*);
